[rtl/lcas_pkg.sv]
// Package for the load cell average and scale block: widths, limits,
// configuration register codes and the structs passed between submodules.
// No dependencies.
package lcas_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int SUM_W       = 32;
  localparam int COUNT_W     = 8;
  localparam int TARE_W      = 24;
  localparam int FACTOR_W    = 32;
  localparam int WEIGHT_W    = 48;
  localparam int AVG_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COUNT_W-1:0] MAX_AVERAGE = 8'd255;

  // Shared divider: 63-bit magnitude dividend, 32-bit magnitude divisor
  localparam int DVD_W  = 63;
  localparam int DVS_W  = 32;
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] AVG_STEPS = 6'd32;
  localparam logic [STEP_W-1:0] WT_STEPS  = 6'd63;

  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AVERAGE_COUNT  = 2'd0,
    REG_TARE_OFFSET    = 2'd1,
    REG_SCALE_FACTOR   = 2'd2,
    REG_ALLOW_NEGATIVE = 2'd3
  } lcas_reg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]         average_count;
    logic signed [TARE_W-1:0]   tare_offset;
    logic signed [FACTOR_W-1:0] scale_factor;
    logic                       allow_negative;
  } lcas_cfg_t;

  // One finished accumulation, waiting for the back end
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } lcas_job_t;

  typedef struct packed {
    logic               start;
    logic [STEP_W-1:0]  steps;
    logic [DVD_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
  } lcas_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DVD_W-1:0]   quotient;
  } lcas_div_rsp_t;

endpackage

[rtl/lcas_if.sv]
// Handshake channels of the load cell block: raw samples in, weights out.
// Depends on lcas_pkg for field widths.
interface lcas_sample_if import lcas_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface lcas_result_if import lcas_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [AVG_W-1:0]    average_reading;
  logic                       saturated;
  logic                       factor_zero;

  modport source (output valid, output weight, output average_reading,
                  output saturated, output factor_zero, input ready);
  modport sink   (input valid, input weight, input average_reading,
                  input saturated, input factor_zero, output ready);
endinterface

[rtl/lcas_front.sv]
// Front end: takes raw samples, sign-extends and accumulates them, and hands
// a finished sum with its count to the job queue. Depends on lcas_pkg, lcas_if.
module lcas_front import lcas_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] eff_count,
  lcas_sample_if.sink        samples,
  input  logic               q_full,
  output logic               push,
  output lcas_job_t          push_job
);

  logic [SUM_W-1:0]   running_sum;
  logic [COUNT_W-1:0] samples_taken;
  logic [SUM_W-1:0]   sample_ext;
  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W:0]   taken_next;
  logic               accept;
  logic               last;

  assign samples.ready = !q_full;
  assign accept        = samples.valid && samples.ready;

  assign sample_ext = {{(SUM_W-SAMPLE_BITS){samples.raw_sample[SAMPLE_BITS-1]}},
                       samples.raw_sample[SAMPLE_BITS-1:0]};
  assign sum_next   = running_sum + sample_ext;
  assign taken_next = {1'b0, samples_taken} + 1'b1;
  // a lowered count mid-average closes the batch at once
  assign last       = taken_next >= {1'b0, eff_count};

  assign push           = accept && last;
  assign push_job.sum   = sum_next;
  assign push_job.count = eff_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      samples_taken <= '0;
    end else if (accept) begin
      if (last) begin
        running_sum   <= '0;
        samples_taken <= '0;
      end else begin
        running_sum   <= sum_next;
        samples_taken <= taken_next[COUNT_W-1:0];
      end
    end
  end

endmodule

[rtl/lcas_queue.sv]
// Short job queue between the accumulating front end and the scaling back end.
// Depends on lcas_pkg for the job type and depth.
module lcas_queue import lcas_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  lcas_job_t push_job,
  output logic      full,
  input  logic      pop,
  output lcas_job_t pop_job,
  output logic      empty
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  lcas_job_t         mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full    = fill == FILL_W'(QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/lcas_div.sv]
// Shared restoring divider, one quotient bit per cycle, unsigned magnitudes.
// The dividend is left aligned so that req.steps bits give the full quotient.
// Depends on lcas_pkg.
module lcas_div import lcas_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  lcas_div_req_t req,
  output lcas_div_rsp_t rsp
);

  logic [DVS_W-1:0]  rem;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  divisor;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DVS_W:0]    partial;
  logic [DVS_W:0]    trial;
  logic              take;

  assign partial = {rem, dvd[DVD_W-1]};
  assign trial   = partial - {1'b0, divisor};
  assign take    = partial >= {1'b0, divisor};

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // quotient bits shift in from the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      dvd     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= take ? trial[DVS_W-1:0] : partial[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], take};
    end
  end

endmodule

[rtl/lcas_back.sv]
// Back end: takes one job from the queue, divides the sum by the count,
// applies tare and clamp, divides by the scale factor unless it is zero, saturates
// and holds the result in the output register. Depends on lcas_pkg, lcas_if, lcas_div.
module lcas_back import lcas_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  lcas_cfg_t     cfg,
  input  logic          q_empty,
  input  lcas_job_t     pop_job,
  output logic          pop,
  lcas_result_if.source results
);

  typedef enum logic [1:0] {ST_IDLE, ST_AVG, ST_WT, ST_OUT} state_t;

  state_t                     state;
  lcas_div_req_t              div_req;
  lcas_div_rsp_t              div_rsp;
  logic                       sum_neg;
  logic                       wt_neg;
  logic signed [WEIGHT_W-1:0] res_weight;
  logic signed [AVG_W-1:0]    res_avg;
  logic                       res_sat;
  logic                       res_fz;

  logic [SUM_W-1:0]           sum_mag;
  logic [SUM_W-1:0]           avg_mag;
  logic signed [SUM_W:0]      avg;
  logic signed [SUM_W+1:0]    diff;
  logic signed [SUM_W+1:0]    diff_c;
  logic [SUM_W+1:0]           diff_mag;
  logic [FACTOR_W-1:0]        factor_mag;
  logic [DVD_W-1:0]           q;

  lcas_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign pop = (state == ST_IDLE) && !q_empty;

  assign sum_mag = pop_job.sum[SUM_W-1] ? (~pop_job.sum + 1'b1) : pop_job.sum;
  assign avg_mag = div_rsp.quotient[SUM_W-1:0];
  assign avg     = sum_neg ? -$signed({1'b0, avg_mag}) : $signed({1'b0, avg_mag});
  assign diff    = (SUM_W+2)'(avg) - (SUM_W+2)'(cfg.tare_offset);
  assign diff_c  = (!cfg.allow_negative && diff[SUM_W+1]) ? '0 : diff;
  assign diff_mag = diff_c[SUM_W+1] ? (~diff_c + 1'b1) : diff_c;
  assign factor_mag = cfg.scale_factor[FACTOR_W-1] ? (~cfg.scale_factor + 1'b1)
                                                   : cfg.scale_factor;
  assign q = div_rsp.quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      div_req.start   <= 1'b0;
      results.valid   <= 1'b0;
    end else begin
      // ST_OUT drives valid itself
      if (results.valid && results.ready && state != ST_OUT) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          div_req.start <= !q_empty;
          if (!q_empty) begin
            sum_neg          <= pop_job.sum[SUM_W-1];
            div_req.steps    <= AVG_STEPS;
            div_req.dividend <= {sum_mag, (DVD_W-SUM_W)'(0)};
            div_req.divisor  <= DVS_W'(pop_job.count);
            state            <= ST_AVG;
          end
        end
        ST_AVG: begin
          div_req.start <= div_rsp.done && (cfg.scale_factor != '0);
          if (div_rsp.done) begin
            res_avg <= avg[AVG_W-1:0];
            res_sat <= 1'b0;
            wt_neg  <= diff_c[SUM_W+1] ^ cfg.scale_factor[FACTOR_W-1];
            if (cfg.scale_factor == '0) begin
              res_weight <= '0;
              res_fz     <= 1'b1;
              state      <= ST_OUT;
            end else begin
              res_fz           <= 1'b0;
              div_req.steps    <= WT_STEPS;
              // |diff| stays below 2^31, so diff * 2^32 fits the dividend
              div_req.dividend <= {diff_mag[DVD_W-SUM_W-1:0], SUM_W'(0)};
              div_req.divisor  <= factor_mag;
              state            <= ST_WT;
            end
          end
        end
        ST_WT: begin
          div_req.start <= 1'b0;
          if (div_rsp.done) begin
            if (!wt_neg) begin
              if (q > {(DVD_W-WEIGHT_W)'(0), WEIGHT_MAX}) begin
                res_weight <= WEIGHT_MAX;
                res_sat    <= 1'b1;
              end else begin
                res_weight <= q[WEIGHT_W-1:0];
              end
            end else begin
              if (q > {(DVD_W-WEIGHT_W)'(0), WEIGHT_MIN}) begin
                res_weight <= WEIGHT_MIN;
                res_sat    <= 1'b1;
              end else begin
                res_weight <= -$signed(q[WEIGHT_W-1:0]);
              end
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          div_req.start <= 1'b0;
          // wait for the output register to free up
          if (!results.valid || results.ready) begin
            results.valid           <= 1'b1;
            results.weight          <= res_weight;
            results.average_reading <= res_avg;
            results.saturated       <= res_sat;
            results.factor_zero     <= res_fz;
            state                   <= ST_IDLE;
          end
        end
        default: begin
          div_req.start <= 1'b0;
          state         <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/load_cell_average_and_scale_core.sv]
// Load cell average and scale core. Raw 24-bit converter words are taken one
// per cycle while the two-entry job queue has room; every average_count words
// the accumulated sum becomes a job, and the back end turns it into one weight
// result. The back end works each job through the shared one-bit-per-cycle
// divider: 32 steps for the average, then 63 steps for the division by the
// scale factor (skipped when the factor is zero). The finished result sits
// in an output register, so the back end starts on the next job while it
// waits to be taken.
// Depends on lcas_pkg, lcas_if, lcas_front, lcas_queue, lcas_div, lcas_back.
module load_cell_average_and_scale_core import lcas_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  lcas_sample_if.sink           samples,
  lcas_result_if.source         results
);

  lcas_cfg_t          cfg;
  logic [COUNT_W-1:0] eff_count;
  logic               push;
  lcas_job_t          push_job;
  logic               q_full;
  logic               q_empty;
  logic               pop;
  lcas_job_t          pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.average_count  <= COUNT_W'(1);
      cfg.tare_offset    <= '0;
      cfg.scale_factor   <= FACTOR_W'(65536);
      cfg.allow_negative <= 1'b0;
    end else if (cfg_we) begin
      unique case (lcas_reg_t'(cfg_index))
        REG_AVERAGE_COUNT:  cfg.average_count  <= cfg_wdata[COUNT_W-1:0];
        REG_TARE_OFFSET:    cfg.tare_offset    <= cfg_wdata[TARE_W-1:0];
        REG_SCALE_FACTOR:   cfg.scale_factor   <= cfg_wdata[FACTOR_W-1:0];
        REG_ALLOW_NEGATIVE: cfg.allow_negative <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // a count of zero acts as one; clamp to the supported maximum
  always_comb begin
    eff_count = cfg.average_count;
    if (eff_count == '0) begin
      eff_count = COUNT_W'(1);
    end else if (eff_count > MAX_AVERAGE) begin
      eff_count = MAX_AVERAGE;
    end
  end

  lcas_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .eff_count (eff_count),
    .samples   (samples),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  lcas_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  lcas_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .pop_job (pop_job),
    .pop     (pop),
    .results (results)
  );

endmodule

[rtl/lcas_checker.sv]
// Port-level checks on the result channel of the load cell core, and the
// bind that attaches them. Depends on lcas_pkg and the core's port list.
module lcas_checker import lcas_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [WEIGHT_W-1:0] weight,
  input logic signed [AVG_W-1:0]    average_reading,
  input logic                       saturated,
  input logic                       factor_zero
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transaction");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(weight) && $stable(average_reading)
                                && $stable(saturated) && $stable(factor_zero))
    else $error("result payload changed while stalled");

  a_zero_factor: assert property (@(posedge clk) disable iff (rst)
    out_valid && factor_zero |-> weight == '0 && !saturated)
    else $error("zero factor with nonzero weight or saturation");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> weight == WEIGHT_MAX || weight == WEIGHT_MIN)
    else $error("saturated weight not at a range limit");

endmodule

bind load_cell_average_and_scale_core lcas_checker u_lcas_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .weight          (results.weight),
  .average_reading (results.average_reading),
  .saturated       (results.saturated),
  .factor_zero     (results.factor_zero)
);
